/* rtl/ttceb_pkg.sv */
// Shared constants, codes and the build-time cosine function for the emergency brake.
`default_nettype none

package ttceb_pkg;

	// Default build parameters
	localparam int NUM_BEAMS_DEF        = 1080;
	localparam int FIRST_ANGLE_URAD_DEF = -3141593;
	localparam int ANGLE_STEP_URAD_DEF  = 5818;
	localparam int COS_FRAC_BITS_DEF    = 14;

	// Field widths
	localparam int BEAM_W  = 11;
	localparam int SPEED_W = 16;
	localparam int RANGE_W = 16;
	localparam int TIME_W  = 16;
	localparam int COS_W   = 16;
	localparam int CFG_W   = 16;
	localparam int ADDR_W  = 2;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Register indexes
	localparam logic [ADDR_W-1:0] CFG_START_INDEX = 2'd0;
	localparam logic [ADDR_W-1:0] CFG_END_INDEX   = 2'd1;
	localparam logic [ADDR_W-1:0] CFG_BRAKE_TIME  = 2'd2;

	// Register reset values
	localparam logic [BEAM_W-1:0] START_INDEX_RST = 11'd0;
	localparam logic [BEAM_W-1:0] END_INDEX_RST   = 11'd1079;
	localparam logic [TIME_W-1:0] BRAKE_TIME_RST  = 16'd600;

	// Item kinds carried in tuser
	localparam logic ACT_SPEED = 1'b0;
	localparam logic ACT_RANGE = 1'b1;

	// Range is in mm, time in ms, speed in mm/s
	localparam logic [MUL_B_W-1:0] MS_PER_S = 32'd1000;

	// Angle constants in microradians and the Q format of the series
	localparam longint TWO_PI_URAD  = 64'sd6283185;
	localparam longint PI_URAD      = 64'sd3141593;
	localparam longint HALF_PI_URAD = 64'sd1570796;
	localparam longint URAD_PER_RAD = 64'sd1000000;
	localparam longint URAD_HALF    = 64'sd500000;
	localparam int     Q_BITS       = 28;
	localparam longint COS_MAX      = 64'sd32767;

	// Cosine of an angle in fixed point, evaluated at elaboration only
	function automatic logic signed [COS_W-1:0] cos_fixed(input longint angle_urad,
		input int frac_bits);
		longint r;
		logic   neg;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint mag;
		r   = angle_urad % TWO_PI_URAD;
		neg = 1'b0;
		if (r < 0)
			r = r + TWO_PI_URAD;
		if (r > PI_URAD - 1)
			r = TWO_PI_URAD - r;
		if (r > HALF_PI_URAD) begin
			neg = 1'b1;
			r   = PI_URAD - r;
		end
		if (r < 0)
			r = 0;
		x    = (r * (64'sd1 <<< Q_BITS) + URAD_HALF) / URAD_PER_RAD;
		x2   = (x * x) >>> Q_BITS;
		term = 64'sd1 <<< Q_BITS;
		sum  = term;
		term = ((term * x2) >>> Q_BITS) / 2;
		sum  = sum - term;
		term = ((term * x2) >>> Q_BITS) / 12;
		sum  = sum + term;
		term = ((term * x2) >>> Q_BITS) / 30;
		sum  = sum - term;
		term = ((term * x2) >>> Q_BITS) / 56;
		sum  = sum + term;
		term = ((term * x2) >>> Q_BITS) / 90;
		sum  = sum - term;
		term = ((term * x2) >>> Q_BITS) / 132;
		sum  = sum + term;
		term = ((term * x2) >>> Q_BITS) / 182;
		sum  = sum - term;
		if (sum < 0)
			sum = 0;
		mag = (sum + (64'sd1 <<< (Q_BITS - frac_bits - 1))) >>> (Q_BITS - frac_bits);
		if (mag > COS_MAX)
			mag = COS_MAX;
		return neg ? COS_W'(-mag) : COS_W'(mag);
	endfunction

endpackage

`default_nettype wire

/* rtl/ttceb_cos_rom.sv */
// Beam cosine ROM built at elaboration, synchronous read.
`default_nettype none

module ttceb_cos_rom #(
	parameter int DEPTH            = ttceb_pkg::NUM_BEAMS_DEF,
	parameter int FIRST_ANGLE_URAD = ttceb_pkg::FIRST_ANGLE_URAD_DEF,
	parameter int ANGLE_STEP_URAD  = ttceb_pkg::ANGLE_STEP_URAD_DEF,
	parameter int COS_FRAC_BITS    = ttceb_pkg::COS_FRAC_BITS_DEF,
	localparam int AW              = $clog2(DEPTH)
) (
	input  wire                                    clk,
	input  wire                                    rd_en,
	input  wire  [AW-1:0]                          rd_addr,
	output logic signed [ttceb_pkg::COS_W-1:0]     rd_data_q
);
	import ttceb_pkg::*;

	logic signed [COS_W-1:0] rom_w [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		assign rom_w[i] = cos_fixed(longint'(FIRST_ANGLE_URAD) +
			longint'(i) * longint'(ANGLE_STEP_URAD), COS_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= rom_w[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/ttceb_mul.sv */
// Shared signed multiplier with registered product.
`default_nettype none

module ttceb_mul (
	input  wire                                    clk,
	input  wire  signed [ttceb_pkg::MUL_A_W-1:0]   a,
	input  wire  signed [ttceb_pkg::MUL_B_W-1:0]   b,
	output logic signed [ttceb_pkg::MUL_P_W-1:0]   p_q
);
	import ttceb_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

`default_nettype wire

/* rtl/ttc_emergency_brake.sv */
// Top level of the time-to-collision emergency brake.
//
// Speed items (tuser[0] = 0) are absorbed in the cycle they are accepted and
// the block stays ready. A range sample goes through a read of the beam
// cosine ROM, then three passes through the single 17 x 32 multiplier
// (speed * cos, brake_time * projected speed, range * 1000) and a final
// compare; s_tready stays low from acceptance until the sequencer is idle.
// The closing test is range_mm * 1000 * 2^COS_FRAC_BITS < brake_time_ms *
// speed * cos, over samples whose beam lies in [start_index, end_index] and
// below NUM_BEAMS. After a brake beat, later samples of the scan are ignored
// until a sample with tlast set. A new brake found while an earlier brake
// beat still waits on m_tready holds the sequencer in its compare step. The
// ROM needs no load after reset.
`default_nettype none

module ttc_emergency_brake #(
	parameter int NUM_BEAMS        = ttceb_pkg::NUM_BEAMS_DEF,
	parameter int FIRST_ANGLE_URAD = ttceb_pkg::FIRST_ANGLE_URAD_DEF,
	parameter int ANGLE_STEP_URAD  = ttceb_pkg::ANGLE_STEP_URAD_DEF,
	parameter int COS_FRAC_BITS    = ttceb_pkg::COS_FRAC_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [47:0]                       s_tdata,   // speed_mm_s, range_mm, beam_index
	input  wire  [1:0]                        s_tuser,   // action, range_valid
	input  wire                               s_tlast,   // last_beam
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [15:0]                       m_tdata,   // brake_beam
	input  wire                               cfg_we,
	input  wire  [ttceb_pkg::ADDR_W-1:0]      cfg_addr,
	input  wire  [ttceb_pkg::CFG_W-1:0]       cfg_wdata
);
	import ttceb_pkg::*;

	localparam int ROM_DEPTH = (NUM_BEAMS < (1 << BEAM_W)) ? NUM_BEAMS : (1 << BEAM_W);
	localparam int AW        = $clog2(ROM_DEPTH);
	localparam int CMP_W     = 48;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PROJ = 3'd1;
	localparam logic [2:0] ST_RHS  = 3'd2;
	localparam logic [2:0] ST_LHS  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;

	logic [2:0]               state_q;
	logic [BEAM_W-1:0]        start_q;
	logic [BEAM_W-1:0]        end_q;
	logic [TIME_W-1:0]        brake_time_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic                     braked_q;
	logic                     check_q;
	logic                     last_q;
	logic                     pos_q;
	logic [RANGE_W-1:0]       range_q;
	logic [BEAM_W-1:0]        beam_q;
	logic [CMP_W-1:0]         rhs_q;
	logic                     m_tvalid_q;
	logic [BEAM_W-1:0]        out_beam_q;

	logic                     accept_w;
	logic                     in_action_w;
	logic [SPEED_W-1:0]       in_speed_w;
	logic [RANGE_W-1:0]       in_range_w;
	logic                     in_valid_w;
	logic [BEAM_W-1:0]        in_beam_w;
	logic                     in_rom_w;
	logic [AW-1:0]            rom_addr_w;
	logic signed [COS_W-1:0]  cos_q;
	logic signed [MUL_A_W-1:0] mul_a_w;
	logic signed [MUL_B_W-1:0] mul_b_w;
	logic signed [MUL_P_W-1:0] prod_q;
	logic [CMP_W-1:0]         lhs_w;
	logic                     hit_w;
	logic                     out_free_w;

	assign in_action_w = s_tuser[0];
	assign in_valid_w  = s_tuser[1];
	assign in_speed_w  = s_tdata[15:0];
	assign in_range_w  = s_tdata[31:16];
	assign in_beam_w   = s_tdata[42:32];

	assign s_tready = (state_q == ST_IDLE);
	assign accept_w = s_tvalid && s_tready;

	assign in_rom_w   = ({2'b00, in_beam_w} < 13'(NUM_BEAMS));
	assign rom_addr_w = in_rom_w ? in_beam_w[AW-1:0] : '0;

	ttceb_cos_rom #(
		.DEPTH            (ROM_DEPTH),
		.FIRST_ANGLE_URAD (FIRST_ANGLE_URAD),
		.ANGLE_STEP_URAD  (ANGLE_STEP_URAD),
		.COS_FRAC_BITS    (COS_FRAC_BITS)
	) u_rom (
		.clk       (clk),
		.rd_en     (accept_w),
		.rd_addr   (rom_addr_w),
		.rd_data_q (cos_q)
	);

	// Steer the shared multiplier by sequencer step
	always_comb begin
		unique case (state_q)
			ST_PROJ: begin
				mul_a_w = MUL_A_W'(speed_q);
				mul_b_w = MUL_B_W'(cos_q);
			end
			ST_RHS: begin
				mul_a_w = {1'b0, brake_time_q};
				mul_b_w = prod_q[MUL_B_W-1:0];
			end
			ST_LHS: begin
				mul_a_w = {1'b0, range_q};
				mul_b_w = MS_PER_S;
			end
			default: begin
				mul_a_w = '0;
				mul_b_w = '0;
			end
		endcase
	end

	ttceb_mul u_mul (
		.clk (clk),
		.a   (mul_a_w),
		.b   (mul_b_w),
		.p_q (prod_q)
	);

	// range * 1000 stays below 2^26; scale it to the cosine fraction
	assign lhs_w      = CMP_W'(prod_q[25:0]) << COS_FRAC_BITS;
	assign hit_w      = check_q && pos_q && (lhs_w < rhs_q);
	assign out_free_w = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= START_INDEX_RST;
			end_q        <= END_INDEX_RST;
			brake_time_q <= BRAKE_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_START_INDEX: start_q      <= cfg_wdata[BEAM_W-1:0];
				CFG_END_INDEX:   end_q        <= cfg_wdata[BEAM_W-1:0];
				CFG_BRAKE_TIME:  brake_time_q <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			speed_q    <= '0;
			braked_q   <= 1'b0;
			check_q    <= 1'b0;
			last_q     <= 1'b0;
			pos_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						if (in_action_w == ACT_SPEED) begin
							speed_q <= in_speed_w;
						end else begin
							check_q <= !braked_q && in_valid_w && in_rom_w &&
								(in_beam_w >= start_q) && (in_beam_w <= end_q);
							last_q  <= s_tlast;
							state_q <= ST_PROJ;
						end
					end
				end
				ST_PROJ: state_q <= ST_RHS;
				ST_RHS: begin
					pos_q   <= (prod_q > 0);
					state_q <= ST_LHS;
				end
				ST_LHS: state_q <= ST_CMP;
				ST_CMP: begin
					// Hold while an earlier brake beat still waits
					if (!hit_w || out_free_w) begin
						braked_q <= (braked_q || hit_w) && !last_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_CMP && hit_w && out_free_w)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_w) begin
			range_q <= in_range_w;
			beam_q  <= in_beam_w;
		end
		if (state_q == ST_LHS)
			rhs_q <= CMP_W'(prod_q[46:0]);
		if (state_q == ST_CMP && hit_w && out_free_w)
			out_beam_q <= beam_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, out_beam_q};

`ifndef NO_ASSERTIONS
	a_out_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_CMP))
		else $error("brake beat raised outside the compare step");

	a_brake_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && hit_w && out_free_w && !last_q) |=> braked_q)
		else $error("scan not marked braked after a brake beat");

	a_speed_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_w && in_action_w == ACT_SPEED) |=> state_q == ST_IDLE)
		else $error("speed item started the sequencer");

	a_no_check_when_braked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROJ) |-> !(check_q && braked_q))
		else $error("sample checked while the scan is braked");
`endif

endmodule

`default_nettype wire

/* sim/ttc_emergency_brake_tb.sv */
// Self-checking testbench for the time-to-collision emergency brake.
`timescale 1ns / 1ps

module ttc_emergency_brake_tb;
	import ttceb_pkg::*;

	localparam int NUM_BEAMS  = NUM_BEAMS_DEF;
	localparam int COS_SHIFT  = COS_FRAC_BITS_DEF;
	localparam longint FIRST_ANGLE = FIRST_ANGLE_URAD_DEF;
	localparam longint ANGLE_STEP  = ANGLE_STEP_URAD_DEF;
	localparam longint TURN_URAD         = 6283185;
	localparam longint HALF_TURN_URAD    = 3141593;
	localparam longint QUARTER_TURN_URAD = 1570796;
	localparam int LUT_Q = 28;

	localparam logic [ADDR_W-1:0] CFG_UNUSED = 2'd3;

	localparam int SEG_COUNT      = 6;
	localparam int SEG_ITEMS      = 170;
	localparam int DRAIN_CYCLES   = 16;
	localparam int TAIL_CYCLES    = 20;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	localparam logic [CFG_W-1:0] SEG_LO   [SEG_COUNT] = '{0, 1079, 0, 200, 0, 0};
	localparam logic [CFG_W-1:0] SEG_HI   [SEG_COUNT] = '{1079, 0, 2047, 880, 1079, 539};
	localparam logic [CFG_W-1:0] SEG_TTC  [SEG_COUNT] = '{600, 2000, 65535, 1500, 3000, 800};

	typedef struct packed {
		logic               action;
		logic signed [15:0] speed;
		logic [15:0]        range;
		logic               valid;
		logic [BEAM_W-1:0]  beam;
		logic               last;
	} sample_t;

	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_BEAM} brake_exp_e;
	typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic [ADDR_W-1:0] addr;
		logic [CFG_W-1:0]  wdata;
		sample_t           item;
		brake_exp_e        chk;
		logic [BEAM_W-1:0] beam;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [47:0]          s_tdata;   // speed_mm_s, range_mm, beam_index
	logic [1:0]           s_tuser;   // action, range_valid
	logic                 s_tlast;   // last_beam
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // brake_beam
	logic                 cfg_we;
	logic [ADDR_W-1:0]    cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;

	// Predictor state and register shadow
	int                 cos_lut [NUM_BEAMS];
	logic signed [15:0] ego_speed;
	bit                 scan_latched;
	logic [BEAM_W-1:0]  win_lo;
	logic [BEAM_W-1:0]  win_hi;
	logic [15:0]        ttc_ms;

	logic [BEAM_W-1:0]  pending_brakes [$];
	step_row_t          plan [$];
	int                 mismatches = 0;
	int                 live_items;
	int                 quiet_cycles = 0;
	int                 src_idle_pct;
	int                 snk_idle_pct;
	bit                 hold_req = 1'b0;

	ttc_emergency_brake uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Fill the beam cosine table: fold the angle into the first quadrant,
	// then sum the series in Q28 and round to the block's fraction bits.
	initial begin : build_cos_lut
		longint ang, r, x, x2, term, acc, mag;
		bit     neg;
		int     i, k;
		for (i = 0; i < NUM_BEAMS; i++) begin
			ang = FIRST_ANGLE + longint'(i) * ANGLE_STEP;
			r   = ang % TURN_URAD;
			neg = 1'b0;
			if (r < 0)
				r = r + TURN_URAD;
			if (r > HALF_TURN_URAD - 1)
				r = TURN_URAD - r;
			if (r > QUARTER_TURN_URAD) begin
				neg = 1'b1;
				r   = HALF_TURN_URAD - r;
			end
			if (r < 0)
				r = 0;
			x    = (r * (64'sd1 <<< LUT_Q) + 500000) / 1000000;
			x2   = (x * x) >>> LUT_Q;
			term = 64'sd1 <<< LUT_Q;
			acc  = term;
			for (k = 1; k <= 7; k++) begin
				term = ((term * x2) >>> LUT_Q) / ((2 * k - 1) * (2 * k));
				acc  = (k % 2) ? acc - term : acc + term;
			end
			if (acc < 0)
				acc = 0;
			mag = (acc + (64'sd1 <<< (LUT_Q - COS_SHIFT - 1))) >>> (LUT_Q - COS_SHIFT);
			if (mag > 32767)
				mag = 32767;
			cos_lut[i] = neg ? -int'(mag) : int'(mag);
		end
	end

	// Returns 1 when the sample commands a brake.
	function automatic bit predict_brake(input sample_t s);
		longint closing, dist_term, limit_term;
		bit     fires;
		fires = 1'b0;
		if (s.action == ACT_SPEED) begin
			ego_speed = s.speed;
			return 1'b0;
		end
		if (!scan_latched && s.beam >= win_lo && s.beam <= win_hi && s.beam < NUM_BEAMS &&
				s.valid) begin
			closing = longint'(ego_speed) * longint'(cos_lut[s.beam]);
			if (closing > 0) begin
				dist_term  = longint'(s.range) * 1000 * (64'sd1 <<< COS_SHIFT);
				limit_term = longint'(ttc_ms) * closing;
				if (dist_term < limit_term) begin
					fires        = 1'b1;
					scan_latched = 1'b1;
				end
			end
		end
		if (s.last)
			scan_latched = 1'b0;
		return fires;
	endfunction

	function automatic step_row_t beat_row(input logic act, input int speed, input int range,
		input logic valid, input int beam, input logic last, input brake_exp_e chk,
		input int want);
		step_row_t row;
		row             = '0;
		row.kind        = ROW_BEAT;
		row.item.action = act;
		row.item.speed  = 16'(speed);
		row.item.range  = 16'(range);
		row.item.valid  = valid;
		row.item.beam   = BEAM_W'(beam);
		row.item.last   = last;
		row.chk         = chk;
		row.beam        = BEAM_W'(want);
		return row;
	endfunction

	function automatic step_row_t write_row(input logic [ADDR_W-1:0] addr,
		input logic [CFG_W-1:0] data);
		step_row_t row;
		row       = '0;
		row.kind  = ROW_WRITE;
		row.addr  = addr;
		row.wdata = data;
		row.chk   = EXP_NONE;
		return row;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Offer one beat, hold it until accepted, then record what it should cause.
	task automatic drive_beat(input sample_t s, input brake_exp_e chk,
		input logic [BEAM_W-1:0] want);
		bit accepted;
		bit fires;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, s.beam, s.range, s.speed};
		s_tuser  <= {s.valid, s.action};
		s_tlast  <= s.last;
		accepted = 1'b0;
		while (!accepted) begin
			@(negedge clk);
			accepted = s_tready;
			@(posedge clk);
		end
		fires = predict_brake(s);
		live_items++;
		case (chk)
			EXP_MODEL: if (fires) pending_brakes.push_back(s.beam);
			EXP_BEAM:  pending_brakes.push_back(want);
			default:   ;
		endcase
	endtask

	// Drop valid and let the block drain before touching its registers.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_brakes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (addr)
			CFG_START_INDEX: win_lo = data[BEAM_W-1:0];
			CFG_END_INDEX:   win_hi = data[BEAM_W-1:0];
			CFG_BRAKE_TIME:  ttc_ms = data;
			default:         ;
		endcase
	endtask

	// Mostly whole scans with random content, the rest raw noise.
	task automatic run_segment(input int target);
		sample_t s;
		int      n_beams, first, stride, k;
		live_items = 0;
		while (live_items < target) begin
			if ($urandom_range(99) < 75) begin
				if ($urandom_range(4) != 0) begin
					s        = '0;
					s.action = ACT_SPEED;
					s.speed  = $urandom_range(1) ? 16'($urandom) :
						16'($urandom_range(3000, 20000));
					if ($urandom_range(1))
						s.speed = -s.speed;
					s.last = ($urandom_range(9) == 0);
					drive_beat(s, EXP_MODEL, '0);
				end
				n_beams = $urandom_range(2, 24);
				first   = $urandom_range(0, NUM_BEAMS - 1);
				stride  = $urandom_range(1, 40);
				for (k = 0; k < n_beams; k++) begin
					s        = '0;
					s.action = ACT_RANGE;
					s.speed  = 16'($urandom);
					s.beam   = BEAM_W'(first + k * stride);
					s.range  = $urandom_range(1) ? 16'($urandom_range(0, 6000)) : 16'($urandom);
					s.valid  = ($urandom_range(9) != 0);
					s.last   = (k == n_beams - 1);
					drive_beat(s, EXP_MODEL, '0);
				end
			end else begin
				s.action = 1'($urandom_range(1));
				s.speed  = 16'($urandom);
				s.range  = 16'($urandom);
				s.valid  = 1'($urandom_range(1));
				s.beam   = BEAM_W'($urandom);
				s.last   = 1'($urandom_range(1));
				drive_beat(s, EXP_MODEL, '0);
			end
		end
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Check each brake beat against the oldest expectation.
	always @(negedge clk) begin : brake_monitor
		logic [BEAM_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_brakes.size() == 0) begin
				report_mismatch($sformatf("unexpected brake beat, beam %0d",
					m_tdata[BEAM_W-1:0]));
			end else begin
				want = pending_brakes.pop_front();
				if (m_tdata[BEAM_W-1:0] !== want)
					report_mismatch($sformatf("brake_beam %0d, expected %0d",
						m_tdata[BEAM_W-1:0], want));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int i, seg;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		s_tlast      = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = '0;
		cfg_wdata    = '0;
		ego_speed    = '0;
		scan_latched = 1'b0;
		win_lo       = 11'd0;
		win_hi       = 11'd1079;
		ttc_ms       = 16'd600;
		src_idle_pct = 16;
		snk_idle_pct = 86;

		// Directed part: defaults after reset, scan latching and re-arm,
		// invalid ranges, beams past the table, empty window, extremes.
		plan.push_back(beat_row(ACT_SPEED, 32767, 0, 1'b0, 0, 1'b0, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 540, 1'b0, EXP_BEAM, 540));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 541, 1'b0, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 600, 1'b1, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 65535, 1'b1, 540, 1'b0, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b0, 540, 1'b0, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 100, 1'b0, EXP_NONE, 0));
		plan.push_back(write_row(CFG_END_INDEX, 16'hFFFF));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 1080, 1'b0, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 2047, 1'b0, EXP_NONE, 0));
		plan.push_back(write_row(CFG_START_INDEX, 16'd600));
		plan.push_back(write_row(CFG_END_INDEX, 16'd500));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 540, 1'b0, EXP_NONE, 0));
		plan.push_back(write_row(CFG_UNUSED, 16'hFFFF));
		plan.push_back(write_row(CFG_START_INDEX, 16'd0));
		plan.push_back(write_row(CFG_END_INDEX, 16'd1079));
		plan.push_back(beat_row(ACT_SPEED, -32768, 0, 1'b0, 0, 1'b0, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 0, 1'b0, EXP_BEAM, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 1079, 1'b1, EXP_NONE, 0));
		plan.push_back(write_row(CFG_BRAKE_TIME, 16'hFFFF));
		plan.push_back(beat_row(ACT_RANGE, 0, 65535, 1'b1, 1079, 1'b1, EXP_BEAM, 1079));
		plan.push_back(beat_row(ACT_RANGE, 0, 65535, 1'b1, 1079, 1'b0, EXP_BEAM, 1079));
		plan.push_back(beat_row(ACT_SPEED, -32768, 0, 1'b0, 0, 1'b1, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 0, 1'b1, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 1234, 1'b1, 150, 1'b1, EXP_MODEL, 0));
		plan.push_back(write_row(CFG_BRAKE_TIME, 16'd0));
		plan.push_back(beat_row(ACT_SPEED, 5000, 0, 1'b0, 0, 1'b0, EXP_NONE, 0));
		plan.push_back(beat_row(ACT_RANGE, 0, 0, 1'b1, 540, 1'b1, EXP_NONE, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].addr, plan[i].wdata);
			end else begin
				drive_beat(plan[i].item, plan[i].chk, plan[i].beam);
			end
		end

		for (seg = 0; seg < SEG_COUNT; seg++) begin
			settle();
			write_reg(CFG_START_INDEX, SEG_LO[seg]);
			write_reg(CFG_END_INDEX, SEG_HI[seg]);
			write_reg(CFG_BRAKE_TIME, SEG_TTC[seg]);
			if (seg == 2) begin
				src_idle_pct = 86;
				snk_idle_pct = 16;
			end
			if (seg == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
				// stall the output long enough to back up the input
				hold_req = 1'b1;
			end
			run_segment(SEG_ITEMS);
		end

		s_tvalid <= 1'b0;
		while (pending_brakes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/ttceb_pkg.sv
rtl/ttceb_cos_rom.sv
rtl/ttceb_mul.sv
rtl/ttc_emergency_brake.sv
sim/ttc_emergency_brake_tb.sv
